// File: hdl/caesar_cipher_fifo_defines.svh
// Assertion macros used by the caesar cipher FIFO top-level RTL file.
`ifndef CAESAR_CIPHER_FIFO_DEFINES_SVH
`define CAESAR_CIPHER_FIFO_DEFINES_SVH
`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define CC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("caesar cipher fifo: check failed");
// Check that a condition implies another in the same cycle.
`define CC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("caesar cipher fifo: implication failed");
// Check that a condition implies another in the next cycle.
`define CC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("caesar cipher fifo: next-cycle check failed");
`else
`define CC_ASSERT(label, clk, rst, prop)
`define CC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/cc_pkg.sv
// Types, constants and alphabet functions for the caesar cipher FIFO.
`timescale 1ns / 1ps
package cc_pkg;

   localparam int CC_FIFO_DEPTH = 256;
   localparam int ALPHA_LEN     = 53;
   localparam int SHIFT_W       = 7;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_SHIFT_ADDR = 2'd0;
   localparam logic [SHIFT_W-1:0]    SHIFT_RESET    = 7'd3;
   // residue of the reset shift over the alphabet
   localparam logic [5:0]            SHIFT_RES_RESET = 6'd3;

   typedef enum logic [0:0] {
      REQ_WRITE = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE      = 1'b0,
      ST_READ_WAIT = 1'b1
   } fsm_state_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [7:0]   data_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  read_data;
      status_type  status;
      logic [8:0]  fill_level;
   } rsp_payload_type;

   typedef struct packed {
      logic       found;
      logic [5:0] idx;
   } alpha_hit_type;

   // Locate a byte in the alphabet: A..Z, space, a..z.
   function automatic alpha_hit_type alpha_index(input logic [7:0] b);
      alpha_hit_type hit;
      hit.found = 1'b0;
      hit.idx   = 6'd0;
      if (b >= 8'd65 && b <= 8'd90) begin
         hit.found = 1'b1;
         hit.idx   = 6'(b - 8'd65);
      end else if (b == 8'd32) begin
         hit.found = 1'b1;
         hit.idx   = 6'd26;
      end else if (b >= 8'd97 && b <= 8'd122) begin
         hit.found = 1'b1;
         hit.idx   = 6'(b - 8'd70);
      end
      return hit;
   endfunction

   // Symbol at an alphabet index in 0..52.
   function automatic logic [7:0] alpha_char(input logic [5:0] idx);
      logic [7:0] c;
      if (idx < 6'd26) begin
         c = 8'd65 + {2'b00, idx};
      end else if (idx == 6'd26) begin
         c = 8'd32;
      end else begin
         c = 8'd70 + {2'b00, idx};
      end
      return c;
   endfunction

   // Reduce a signed 7-bit shift to its residue mod 53.
   function automatic logic [5:0] shift_residue(input logic [SHIFT_W-1:0] s);
      logic [7:0] v;
      // bias by twice the alphabet length: value lands in 42..169
      v = {s[SHIFT_W-1], s} + 8'(2 * ALPHA_LEN);
      if (v >= 8'(2 * ALPHA_LEN)) begin
         v = v - 8'(2 * ALPHA_LEN);
      end
      if (v >= 8'(ALPHA_LEN)) begin
         v = v - 8'(ALPHA_LEN);
      end
      return v[5:0];
   endfunction

endpackage

// File: hdl/cc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module cc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cc_encode.sv
// Caesar substitution of one byte over the 53-symbol alphabet.
`timescale 1ns / 1ps
module cc_encode (
   input  logic [7:0] data_in,
   input  logic [5:0] shift_res,
   output logic [7:0] data_out
);
   import cc_pkg::*;

   alpha_hit_type hit;
   logic [6:0]    sum;

   // look up, rotate by the shift residue, map back
   always_comb begin
      hit = alpha_index(data_in);
      sum = {1'b0, hit.idx} + {1'b0, shift_res};
      if (sum >= 7'(ALPHA_LEN)) begin
         sum = sum - 7'(ALPHA_LEN);
      end
      if (hit.found) begin
         data_out = alpha_char(sum[5:0]);
      end else begin
         data_out = data_in;
      end
   end

endmodule

// File: hdl/caesar_cipher_fifo.sv
// Top level of the caesar cipher FIFO: control, pointers and CSR port.
`timescale 1ns / 1ps
`include "caesar_cipher_fifo_defines.svh"
// Byte FIFO that Caesar-shifts letters and space on the way in. Each request
// is a write (encode and push) or a read (pop); each request yields exactly
// one response with the popped byte, a status (ok, full, empty) and the fill
// level after the request. A write or rejected request needs no wait state;
// a successful read passes through one, as the byte comes from the store's
// registered read port. One request is in flight at a time, and a response
// that the consumer stalls holds the request side until it is taken. The
// store needs no clearing pass after reset. The shift register sits at CSR
// address 0, is signed 7 bits wide (reset 3) and reads back sign-extended.
module caesar_cipher_fifo #(
   parameter int FIFO_DEPTH = cc_pkg::CC_FIFO_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cc_pkg::req_payload_type           req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cc_pkg::rsp_payload_type           rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                              csr_pready
);
   import cc_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   // control state
   fsm_state_type       state_ff, state_in;
   logic [PTR_W-1:0]    wptr_ff, wptr_in;
   logic [PTR_W-1:0]    rptr_ff, rptr_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;
   logic [SHIFT_W-1:0]  shift_ff;
   logic [5:0]          shift_res_ff;

   logic                req_accept;
   logic                csr_wr;
   logic                full;
   logic                empty;
   logic [7:0]          enc_byte;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [7:0]          ram_rd_data;
   logic [CNT_W+8:0]    fill_ext;
   logic [CNT_W+8:0]    fill_inc_ext;
   logic [CNT_W-1:0]    fill_inc;

   // handshakes
   assign req_stall  = (state_ff == ST_READ_WAIT) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign full  = (fill_ff == CNT_W'(FIFO_DEPTH));
   assign empty = (fill_ff == '0);

   // fill level as the 9-bit response field
   assign fill_inc     = fill_ff + 1'b1;
   assign fill_ext     = {9'd0, fill_ff};
   assign fill_inc_ext = {9'd0, fill_inc};

   // CSR port: shift register and its residue
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == CSR_SHIFT_ADDR) ?
                       {{(CSR_DATA_W-SHIFT_W){shift_ff[SHIFT_W-1]}}, shift_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= SHIFT_RESET;
         shift_res_ff <= SHIFT_RES_RESET;
      end else if (csr_wr && csr_paddr == CSR_SHIFT_ADDR) begin
         shift_ff     <= csr_pwdata[SHIFT_W-1:0];
         shift_res_ff <= shift_residue(csr_pwdata[SHIFT_W-1:0]);
      end
   end

   // encode the incoming byte
   cc_encode u_encode (
      .data_in   (req_payload.data_in),
      .shift_res (shift_res_ff),
      .data_out  (enc_byte)
   );

   // byte store
   cc_ram #(
      .WIDTH (8),
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wptr_ff),
      .wr_data (enc_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (rptr_ff),
      .rd_data (ram_rd_data)
   );

   // next state, pointers and response
   always_comb begin
      state_in       = state_ff;
      wptr_in        = wptr_ff;
      rptr_in        = rptr_ff;
      fill_in        = fill_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.read_data = 8'd0;
               rsp_payload_in.fill_level = fill_ext[8:0];
               if (req_payload.req_type == REQ_WRITE) begin
                  if (full) begin
                     rsp_payload_in.status = STATUS_FULL;
                  end else begin
                     // push and advance the write pointer
                     ram_wr_en = 1'b1;
                     wptr_in   = (wptr_ff == PTR_W'(FIFO_DEPTH - 1)) ?
                                 '0 : wptr_ff + 1'b1;
                     fill_in   = fill_inc;
                     rsp_payload_in.status     = STATUS_OK;
                     rsp_payload_in.fill_level = fill_inc_ext[8:0];
                  end
               end else begin
                  if (empty) begin
                     rsp_payload_in.status = STATUS_EMPTY;
                  end else begin
                     // issue the read, respond when the data lands
                     ram_rd_en    = 1'b1;
                     rptr_in      = (rptr_ff == PTR_W'(FIFO_DEPTH - 1)) ?
                                    '0 : rptr_ff + 1'b1;
                     fill_in      = fill_ff - 1'b1;
                     rsp_valid_in = 1'b0;
                     state_in     = ST_READ_WAIT;
                  end
               end
            end
         end
         ST_READ_WAIT: begin
            rsp_valid_in              = 1'b1;
            rsp_payload_in.read_data  = ram_rd_data;
            rsp_payload_in.status     = STATUS_OK;
            rsp_payload_in.fill_level = fill_ext[8:0];
            state_in                  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset
   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   // checks
   `CC_ASSERT(a_fill_bound, clock, reset, fill_ff <= CNT_W'(FIFO_DEPTH))
   `CC_ASSERT_IMPL(a_wait_no_rsp, clock, reset, state_ff == ST_READ_WAIT, !rsp_valid_ff)
   `CC_ASSERT_NEXT(a_read_waits, clock, reset, req_accept && req_payload.req_type == REQ_READ && !empty, state_ff == ST_READ_WAIT && rsp_valid_ff == 1'b0)
   `CC_ASSERT_NEXT(a_wait_responds, clock, reset, state_ff == ST_READ_WAIT, rsp_valid_ff && rsp_payload_ff.status == STATUS_OK)
   `CC_ASSERT_IMPL(a_ptr_balance, clock, reset, empty || full, wptr_ff == rptr_ff)

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the caesar cipher FIFO: predicted responses, random traffic, CSR.
`timescale 1ns / 1ps
module tb_top;
   import cc_pkg::*;

   localparam int DEPTH       = CC_FIFO_DEPTH;
   localparam int CYCLE_LIMIT = 300000;
   // cipher symbols in index order; symbol 0 sits in the top byte
   localparam logic [8*ALPHA_LEN-1:0] CIPHER_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZ abcdefghijklmnopqrstuvwxyz";

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_payload;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // shadow of the FIFO contents, pointers and shift
   logic [7:0]      mdl_store [DEPTH];
   int              mdl_wr_ptr = 0;
   int              mdl_rd_ptr = 0;
   int              mdl_count  = 0;
   int              mdl_shift  = 3;
   rsp_payload_type predicted_rsp_q [$];

   int   err_count   = 0;
   int   cycle_count = 0;
   int   hold_len    = 0;
   logic tx_idle_en  = 1'b1;
   logic rx_idle_en  = 1'b1;

   caesar_cipher_fifo u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [7:0] alphabet_sym(input int k);
      return CIPHER_ALPHABET[8*(ALPHA_LEN-1-k) +: 8];
   endfunction

   // Shift a byte over the alphabet; bytes outside it pass through.
   function automatic logic [7:0] caesar_encode(input logic [7:0] b, input int shift);
      int pos;
      pos = -1;
      for (int k = 0; k < ALPHA_LEN; k++) begin
         if (alphabet_sym(k) == b) pos = k;
      end
      if (pos < 0) return b;
      return alphabet_sym((pos + shift + 2 * ALPHA_LEN) % ALPHA_LEN);
   endfunction

   // Apply one request to the shadow FIFO and queue the response it must give.
   task automatic predict_fifo_op(input req_payload_type req);
      rsp_payload_type r;
      r = '0;
      r.status = STATUS_OK;
      if (req.req_type == REQ_WRITE) begin
         if (mdl_count >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            mdl_store[mdl_wr_ptr] = caesar_encode(req.data_in, mdl_shift);
            mdl_wr_ptr = (mdl_wr_ptr + 1) % DEPTH;
            mdl_count++;
         end
      end else begin
         if (mdl_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.read_data = mdl_store[mdl_rd_ptr];
            mdl_rd_ptr = (mdl_rd_ptr + 1) % DEPTH;
            mdl_count--;
         end
      end
      r.fill_level = 9'(mdl_count);
      predicted_rsp_q.push_back(r);
   endtask

   // Compare one response transfer against the oldest prediction.
   task automatic check_fifo_rsp(input rsp_payload_type got);
      rsp_payload_type want;
      if (predicted_rsp_q.size() == 0) begin
         $display("%0t: response with none pending: read_data=%0h status=%0d fill=%0d",
                  $time, got.read_data, got.status, got.fill_level);
         err_count++;
      end else begin
         want = predicted_rsp_q.pop_front();
         if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch: expected %0h actual %0h",
                     $time, want.read_data, got.read_data);
            err_count++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
            err_count++;
         end
         if (got.fill_level !== want.fill_level) begin
            $display("%0t: fill_level mismatch: expected %0d actual %0d",
                     $time, want.fill_level, got.fill_level);
            err_count++;
         end
      end
   endtask

   // Observe both channels at each edge: predict first, then check.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predict_fifo_op(req_payload);
         if (rsp_valid && !rsp_stall) check_fifo_rsp(rsp_payload);
      end
   end

   // Response side: random stall per transfer, plus long hold-offs on request.
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(negedge clock);
            hold_len = 0;
         end
         n = rx_idle_en ? $urandom_range(0, 5) : 0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid && hold_len == 0);
         @(negedge clock);
      end
   end

   // Bound the run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("caesar_cipher_fifo test failed");
      $finish;
   end

   // Offer one request after a random gap and hold it until the transfer.
   task automatic send_item(input req_kind_type kind, input logic [7:0] data);
      int gap;
      gap = tx_idle_en ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{req_type: kind, data_in: data};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Mostly alphabet symbols on writes, arbitrary bytes otherwise.
   task automatic send_random_item(input int write_pct);
      logic [7:0] b;
      if ($urandom_range(0, 99) < write_pct) begin
         if ($urandom_range(0, 3) != 0) b = alphabet_sym($urandom_range(0, ALPHA_LEN - 1));
         else b = 8'($urandom);
         send_item(REQ_WRITE, b);
      end else begin
         send_item(REQ_READ, 8'($urandom));
      end
   endtask

   // Drop valid and drain every pending response.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == CSR_SHIFT_ADDR) mdl_shift = int'($signed(data[SHIFT_W-1:0]));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Read a register and compare against the sign-extended shadow value.
   task automatic csr_read_check(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $display("%0t: CSR readback mismatch: expected %0h actual %0h",
                  $time, want, csr_prdata);
         err_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_shift(input int s);
      wait_idle();
      csr_write(CSR_SHIFT_ADDR, 32'(s));
      csr_read_check(CSR_SHIFT_ADDR, 32'(mdl_shift));
   endtask

   // Shift comes out of reset at 3.
   task automatic test_reset_shift();
      csr_read_check(CSR_SHIFT_ADDR, 32'(mdl_shift));
   endtask

   // Empty read, alphabet edges, neighbors just outside, wrap past 'z'.
   task automatic test_directed();
      logic [7:0] bytes [16] = '{8'h41, 8'h5A, 8'h20, 8'h61, 8'h7A, 8'h40, 8'h5B, 8'h60,
                                 8'h7B, 8'h00, 8'hFF, 8'h1F, 8'h21, 8'h78, 8'h79, 8'h58};
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      send_item(REQ_READ, 8'hA5);
      foreach (bytes[i]) send_item(REQ_WRITE, bytes[i]);
      repeat (8) send_item(REQ_READ, 8'h00);
      wait_idle();
   endtask

   // Fill to capacity, push past full, then drain past empty.
   task automatic test_full_and_empty();
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      while (mdl_count < DEPTH) send_random_item(100);
      repeat (3) send_random_item(100);
      while (mdl_count > 0) send_random_item(0);
      repeat (3) send_random_item(0);
      wait_idle();
   endtask

   // Step through extreme and boundary shifts, including out-of-range ones.
   task automatic test_shift_sweep();
      int shifts [10] = '{-64, 63, -52, 52, 53, -53, 0, -1, 26, -27};
      foreach (shifts[i]) begin
         set_shift(shifts[i]);
         tx_idle_en = $urandom_range(0, 2) != 0;
         rx_idle_en = $urandom_range(0, 2) != 0;
         repeat (30) send_random_item(55);
      end
   endtask

   // Hold the response side off while requests keep coming.
   task automatic test_backpressure();
      wait_idle();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b1;
      hold_len = 200;
      repeat (30) send_random_item(60);
      wait_idle();
   endtask

   // Random shifts, random read/write mix per phase.
   task automatic test_random_mix();
      int wpct;
      for (int p = 0; p < 6; p++) begin
         set_shift(int'($signed(7'($urandom_range(0, 127)))));
         tx_idle_en = $urandom_range(0, 3) != 0;
         rx_idle_en = $urandom_range(0, 3) != 0;
         wpct = $urandom_range(20, 80);
         repeat (40) send_random_item(wpct);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_shift();
      test_directed();
      test_full_and_empty();
      test_shift_sweep();
      test_backpressure();
      test_random_mix();

      wait_idle();
      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("caesar_cipher_fifo test passed");
      end else begin
         $display("caesar_cipher_fifo test failed");
      end
      $finish;
   end

endmodule

// File: caesar_cipher_fifo.f
+incdir+hdl
hdl/cc_pkg.sv
hdl/cc_ram.sv
hdl/cc_encode.sv
hdl/caesar_cipher_fifo.sv
tb/tb_top.sv
